// File: design/mav_pkg.sv
`default_nettype none

package mav_pkg;

    // payload widths of the channels
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // largest window the 7-bit length register can express
    localparam int WINDOW_FIELD_MAX = 127;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd1;

    // reset values of the registers
    localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 7'd1;

    // control sequence for one item
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } mav_state_t;

endpackage

`default_nettype wire

// File: design/mav_if.sv
`default_nettype none

// sample channel
interface mav_in_if;
    logic                          valid;
    logic                          ready;
    logic [mav_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// average channel
interface mav_out_if;
    logic                          valid;
    logic                          ready;
    logic [mav_pkg::SAMPLE_W-1:0]  average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

// register write channel
interface mav_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mav_pkg::CFG_IDX_W-1:0]   index;
    logic [mav_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/mav_store.sv
`default_nettype none

module mav_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [mav_pkg::SAMPLE_W-1:0] wr_data,
    output logic      [mav_pkg::SAMPLE_W-1:0] rd_data
);

    logic [mav_pkg::SAMPLE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/mav_divider.sv
`default_nettype none

module mav_divider #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] rem_next;
    logic             q_bit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        q_bit = !diff[DVS_W];
        if (q_bit)
        begin
            rem_next = diff[DVS_W-1:0];
        end
        else
        begin
            rem_next = trial[DVS_W-1:0];
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // quotient and remainder datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/moving_average_word.sv
// channel  | role  | payload                   | transfer
// ---------+-------+---------------------------+---------------------
// samples  | sink  | sample [15:0]             | valid && ready
// averages | source| average [15:0]            | valid && ready
// cfg      | sink  | index [1:0], data [6:0]   | valid && ready (ready held high)
//
// An enabled item's store read, issued at acceptance, returns in the update
// cycle; then come SUM_W steps of the restoring divider and the output load,
// once the averages channel is free; the next item is taken back in idle. A
// disabled item skips store and divider; its zero result is loaded in the divide state.
// Reset restores the registers' reset values and clears the running sum,
// position and fill count; the sample store is never cleared, entries count once written.
// A result waiting on a stalled averages channel holds off the next result,
// while the next item may already be accepted and processed.
`default_nettype none

module moving_average_word #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mav_in_if.sink     samples,
    mav_out_if.source  averages,
    mav_cfg_if.sink    cfg
);

    localparam int LEN_MAX = (WINDOW_MAX < mav_pkg::WINDOW_FIELD_MAX) ?
                             WINDOW_MAX : mav_pkg::WINDOW_FIELD_MAX;
    localparam int CNT_W   = $clog2(LEN_MAX + 1);
    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
    localparam int SUM_W   = mav_pkg::SAMPLE_W + $clog2(LEN_MAX);

    mav_pkg::mav_state_t state_reg, state_next;

    logic [mav_pkg::CFG_DATA_W-1:0] window_reg, window_next;
    logic                           enable_reg, enable_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [SLOT_W-1:0]              addr_reg, addr_next;
    logic [mav_pkg::SAMPLE_W-1:0]   sample_reg, sample_next;
    logic                           zero_reg, zero_next;
    logic                           out_valid_reg, out_valid_next;
    logic [mav_pkg::SAMPLE_W-1:0]   average_reg, average_next;

    logic                           in_accept;
    logic                           cfg_accept;
    logic                           out_free;
    logic [CNT_W-1:0]               len_eff;
    logic [SLOT_W-1:0]              slot_cur;
    logic [CMP_W-1:0]               slot_inc;
    logic [SUM_W-1:0]               leaving;

    logic                           rd_en;
    logic                           wr_en;
    logic [mav_pkg::SAMPLE_W-1:0]   rd_data;
    logic                           div_start;
    logic [CNT_W-1:0]               div_divisor;
    logic                           div_done;
    logic [SUM_W-1:0]               div_quotient;

    // sample ring store
    mav_store #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (SLOT_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (slot_cur),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (sample_reg),
        .rd_data (rd_data)
    );

    // sum divided by the sample count
    mav_divider #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // handshakes
    assign samples.ready  = (state_reg == mav_pkg::ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign averages.valid = out_valid_reg;
    assign averages.average = average_reg;

    assign in_accept  = samples.valid && samples.ready;
    assign cfg_accept = cfg.valid && cfg.ready;
    assign out_free   = !out_valid_reg || averages.ready;

    // window length clamped to 1..LEN_MAX
    always_comb
    begin
        if (window_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (window_reg > mav_pkg::CFG_DATA_W'(LEN_MAX))
        begin
            len_eff = CNT_W'(LEN_MAX);
        end
        else
        begin
            len_eff = CNT_W'(window_reg);
        end
    end

    // current slot, folded back to zero when past the window
    always_comb
    begin
        if (CMP_W'(slot_reg) >= CMP_W'(len_eff))
        begin
            slot_cur = '0;
        end
        else
        begin
            slot_cur = slot_reg;
        end
        slot_inc = CMP_W'(addr_reg) + CMP_W'(1);
    end

    // sequencer: the store read at acceptance returns in the update cycle,
    // and the write of one item lands before the next item's read
    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        enable_next    = enable_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        addr_next      = addr_reg;
        sample_next    = sample_reg;
        zero_next      = zero_reg;
        average_next   = average_reg;
        out_valid_next = out_valid_reg && !averages.ready;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;
        div_divisor    = len_eff;
        leaving        = '0;

        unique case (state_reg)
            mav_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = samples.sample;
                    addr_next   = slot_cur;
                    zero_next   = !enable_reg;
                    rd_en       = enable_reg;
                    if (enable_reg)
                    begin
                        state_next = mav_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = mav_pkg::ST_DIVIDE;
                    end
                end
            end
            mav_pkg::ST_UPDATE:
            begin
                // leaving sample counts only once the window is full
                if (fill_reg >= len_eff)
                begin
                    leaving = SUM_W'(rd_data);
                end
                sum_next = sum_reg - leaving + SUM_W'(sample_reg);
                wr_en    = 1'b1;
                if (slot_inc >= CMP_W'(len_eff))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_inc[SLOT_W-1:0];
                end
                if (fill_reg < len_eff)
                begin
                    fill_next   = fill_reg + CNT_W'(1);
                    div_divisor = fill_reg + CNT_W'(1);
                end
                div_start  = 1'b1;
                state_next = mav_pkg::ST_DIVIDE;
            end
            mav_pkg::ST_DIVIDE:
            begin
                if ((zero_reg || div_done) && out_free)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        average_next = '0;
                    end
                    else
                    begin
                        average_next = div_quotient[mav_pkg::SAMPLE_W-1:0];
                    end
                    state_next = mav_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mav_pkg::ST_IDLE;
            end
        endcase

        // writes to the window length and enable registers clear the window progress
        if (cfg_accept)
        begin
            unique case (cfg.index)
                mav_pkg::CFG_WINDOW_LENGTH:
                begin
                    window_next = cfg.data;
                    sum_next    = '0;
                    slot_next   = '0;
                    fill_next   = '0;
                end
                mav_pkg::CFG_ENABLE:
                begin
                    enable_next = cfg.data[0];
                    sum_next    = '0;
                    slot_next   = '0;
                    fill_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mav_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= mav_pkg::WINDOW_RESET;
            enable_reg    <= 1'b0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            enable_reg    <= enable_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        sample_reg  <= sample_next;
        average_reg <= average_next;
    end

endmodule

`default_nettype wire

// File: design/mav_checker.sv
`default_nettype none

module mav_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [mav_pkg::SAMPLE_W-1:0] average
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items accepted whose result has not been taken yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average))
        else $error("average changed while stalled");

    // no result without an item behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted item");

    // at most one item in work besides a waiting result
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg <= 2'd1)
        else $error("item accepted with two results outstanding");

    // one item at a time through the sequencer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("item accepted while the previous one is in work");

endmodule

bind moving_average_word mav_checker u_mav_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (averages.valid),
    .out_ready (averages.ready),
    .average   (averages.average)
);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WINDOW_MAX  = 64;
    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int PAUSE_AT    = 800;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_CYCLES  = 60;

    // register indexes the block does not decode
    localparam logic [mav_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [mav_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [0:0] {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [mav_pkg::CFG_IDX_W-1:0]      index;
        logic [mav_pkg::CFG_DATA_W-1:0]     data;
        logic [mav_pkg::SAMPLE_W-1:0]       sample;
        bit                                 has_fixed;
        logic [mav_pkg::SAMPLE_W-1:0]       fixed_avg;
    } row_t;

    logic clk;
    logic rst_n;

    mav_in_if  samples_ch ();
    mav_out_if averages_ch ();
    mav_cfg_if cfg_ch ();

    moving_average_word #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .averages (averages_ch),
        .cfg      (cfg_ch)
    );

    // window model state
    logic [mav_pkg::SAMPLE_W-1:0]   win_store [WINDOW_MAX];
    logic [21:0]                    win_sum;
    int unsigned                    win_slot;
    int unsigned                    win_fill;
    logic [mav_pkg::CFG_DATA_W-1:0] reg_window;
    bit                             reg_enable;

    logic [mav_pkg::SAMPLE_W-1:0] avg_expect_q [$];
    row_t                         dir_rows [$];

    int  fail_count;
    int  items_sent;
    bit  tx_burst;
    bit  rx_burst;
    bit  hold_req;
    bit  cur_has_fixed;
    logic [mav_pkg::SAMPLE_W-1:0] cur_fixed_avg;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what,
                                   input logic [mav_pkg::SAMPLE_W-1:0] got,
                                   input logic [mav_pkg::SAMPLE_W-1:0] want);
        $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // register write as the block sees it
    function automatic void apply_write(input logic [mav_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [mav_pkg::CFG_DATA_W-1:0] val);
        if (idx == mav_pkg::CFG_WINDOW_LENGTH || idx == mav_pkg::CFG_ENABLE)
        begin
            if (idx == mav_pkg::CFG_WINDOW_LENGTH)
                reg_window = val;
            else
                reg_enable = val[0];
            win_sum  = '0;
            win_slot = 0;
            win_fill = 0;
        end
    endfunction

    // one sample into the window, returns the truncated mean, or zero while disabled
    function automatic logic [mav_pkg::SAMPLE_W-1:0] predict_average(
        input logic [mav_pkg::SAMPLE_W-1:0] s);
        int unsigned len;
        int unsigned slot;
        int unsigned divisor;
        logic [mav_pkg::SAMPLE_W-1:0] leaving;
        if (!reg_enable)
            return '0;
        len = reg_window;
        if (len == 0)
            len = 1;
        if (len > WINDOW_MAX)
            len = WINDOW_MAX;
        slot = win_slot;
        if (slot >= len)
            slot = 0;
        leaving = '0;
        if (win_fill >= len)
            leaving = win_store[slot];
        win_sum = win_sum - 22'(leaving) + 22'(s);
        win_store[slot] = s;
        slot++;
        if (slot >= len)
            slot = 0;
        win_slot = slot;
        if (win_fill < len)
        begin
            win_fill++;
            divisor = win_fill;
        end
        else
            divisor = len;
        return mav_pkg::SAMPLE_W'(32'(win_sum) / divisor);
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_item(input logic [mav_pkg::SAMPLE_W-1:0] s,
                                     input bit has_fixed,
                                     input logic [mav_pkg::SAMPLE_W-1:0] fixed_avg);
        row_t r;
        r.kind      = ROW_ITEM;
        r.index     = '0;
        r.data      = '0;
        r.sample    = s;
        r.has_fixed = has_fixed;
        r.fixed_avg = fixed_avg;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_write(input logic [mav_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [mav_pkg::CFG_DATA_W-1:0] val);
        row_t r;
        r.kind      = ROW_WRITE;
        r.index     = idx;
        r.data      = val;
        r.sample    = '0;
        r.has_fixed = 1'b0;
        r.fixed_avg = '0;
        dir_rows.push_back(r);
    endfunction

    // offer one sample item, returns at the falling edge after acceptance
    task automatic send_item(input logic [mav_pkg::SAMPLE_W-1:0] s, input bit has_fixed,
                             input logic [mav_pkg::SAMPLE_W-1:0] fixed_avg);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            samples_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid  = 1'b1;
        samples_ch.sample = s;
        cur_has_fixed     = has_fixed;
        cur_fixed_avg     = fixed_avg;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait for every expected average
    task automatic wait_drained();
        samples_ch.valid = 1'b0;
        while (avg_expect_q.size() != 0)
            @(negedge clk);
        repeat ($urandom_range(0, 3)) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mav_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mav_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [mav_pkg::SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return mav_pkg::SAMPLE_W'($urandom);
    endfunction

    // handshake monitor: checks averages, feeds the window model
    always @(posedge clk)
    begin : chan_monitor
        logic [mav_pkg::SAMPLE_W-1:0] want;
        logic [mav_pkg::SAMPLE_W-1:0] model_avg;
        if (rst_n)
        begin
            if (averages_ch.valid && averages_ch.ready)
            begin
                if (avg_expect_q.size() == 0)
                    report_mismatch("average with no item waiting", averages_ch.average, '0);
                else
                begin
                    want = avg_expect_q.pop_front();
                    if (averages_ch.average !== want)
                        report_mismatch("average", averages_ch.average, want);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_write(cfg_ch.index, cfg_ch.data);
            if (samples_ch.valid && samples_ch.ready)
            begin
                model_avg = predict_average(samples_ch.sample);
                avg_expect_q.push_back(cur_has_fixed ? cur_fixed_avg : model_avg);
            end
        end
    end

    // average sink with random stalls and one long hold-off
    initial
    begin : avg_sink
        int stall_left;
        int gap;
        stall_left        = 0;
        averages_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                averages_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                gap = pick_gap(rx_burst);
                averages_ch.ready = (gap == 0);
                if (gap > 0)
                    stall_left = gap - 1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) ||
                (averages_ch.valid && averages_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("[moving_average_word] ERROR");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int pick;
        int eff_len;
        int n_items;
        logic [mav_pkg::CFG_DATA_W-1:0] win_val;
        logic [mav_pkg::CFG_DATA_W-1:0] en_val;

        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = mav_pkg::CFG_WINDOW_LENGTH;
        cfg_ch.data       = '0;
        fail_count        = 0;
        items_sent        = 0;
        tx_burst          = 1'b0;
        rx_burst          = 1'b0;
        hold_req          = 1'b0;
        cur_has_fixed     = 1'b0;
        cur_fixed_avg     = '0;
        reg_window        = mav_pkg::WINDOW_RESET;
        reg_enable        = 1'b0;
        win_sum           = '0;
        win_slot          = 0;
        win_fill          = 0;
        foreach (win_store[i])
            win_store[i] = '0;

        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed rows: disabled after reset, window extremes, dead indexes
        add_item(16'hFFFF, 1, 16'h0000);
        add_item(16'h0000, 1, 16'h0000);
        add_write(mav_pkg::CFG_ENABLE, 7'h01);
        add_item(16'hFFFF, 1, 16'hFFFF);
        add_item(16'h0000, 1, 16'h0000);
        add_item(16'h0001, 1, 16'h0001);
        add_write(mav_pkg::CFG_WINDOW_LENGTH, 7'h00);
        add_item(16'h8000, 1, 16'h8000);
        add_item(16'h7FFF, 1, 16'h7FFF);
        add_write(mav_pkg::CFG_WINDOW_LENGTH, 7'h7F);
        add_item(16'hFFFF, 1, 16'hFFFF);
        add_item(16'hFFFF, 1, 16'hFFFF);
        add_item(16'h0000, 0, 16'h0000);
        add_write(mav_pkg::CFG_WINDOW_LENGTH, 7'h02);
        add_item(16'hFFFF, 1, 16'hFFFF);
        add_item(16'h0001, 0, 16'h0000);
        add_item(16'h0000, 0, 16'h0000);
        add_item(16'hFFFF, 0, 16'h0000);
        add_write(CFG_SPARE_2, 7'h7F);
        add_item(16'h1234, 0, 16'h0000);
        add_write(CFG_SPARE_3, 7'h00);
        add_item(16'h4321, 0, 16'h0000);
        add_write(mav_pkg::CFG_ENABLE, 7'h7E);
        add_item(16'hFFFF, 1, 16'h0000);
        add_write(mav_pkg::CFG_WINDOW_LENGTH, 7'h03);
        add_item(16'h5555, 1, 16'h0000);
        add_write(mav_pkg::CFG_ENABLE, 7'h01);
        add_item(16'hAAAA, 1, 16'hAAAA);
        add_item(16'h5555, 0, 16'h0000);
        add_item(16'hFFFF, 0, 16'h0000);
        add_item(16'h0000, 0, 16'h0000);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(dir_rows[i].index, dir_rows[i].data);
            end
            else
                send_item(dir_rows[i].sample, dir_rows[i].has_fixed, dir_rows[i].fixed_avg);
        end

        // random phases, each with its own settings
        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            tx_burst = 1'b0;
            rx_burst = 1'b0;

            pick = $urandom_range(0, 9);
            case (pick)
                0:       win_val = 7'd1;
                1:       win_val = 7'd64;
                2:       win_val = 7'd127;
                3:       win_val = 7'd0;
                4, 5, 6: win_val = mav_pkg::CFG_DATA_W'($urandom_range(1, 8));
                7, 8:    win_val = mav_pkg::CFG_DATA_W'($urandom_range(1, 127));
                default: win_val = mav_pkg::CFG_DATA_W'($urandom_range(9, 64));
            endcase
            en_val = mav_pkg::CFG_DATA_W'($urandom);
            en_val[0] = ($urandom_range(0, 4) != 0);

            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(mav_pkg::CFG_WINDOW_LENGTH, win_val);
                write_reg(mav_pkg::CFG_ENABLE, en_val);
            end
            else
            begin
                write_reg(mav_pkg::CFG_ENABLE, en_val);
                write_reg(mav_pkg::CFG_WINDOW_LENGTH, win_val);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          mav_pkg::CFG_DATA_W'($urandom));

            eff_len = (win_val == 0) ? 1 : ((win_val > WINDOW_MAX) ? WINDOW_MAX : win_val);
            n_items = $urandom_range(8, 30) + 2 * eff_len;
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);

            repeat (n_items)
            begin
                if (items_sent == HOLD_AT)
                    hold_req = 1'b1;
                if (items_sent == PAUSE_AT)
                    wait_drained();
                send_item(random_sample(), 0, '0);
            end
        end

        // drain and let the block settle
        samples_ch.valid = 1'b0;
        while (avg_expect_q.size() != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("[moving_average_word] OK");
        else
            $display("[moving_average_word] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/mav_pkg.sv
design/mav_if.sv
design/mav_store.sv
design/mav_divider.sv
design/moving_average_word.sv
design/mav_checker.sv
sim/tb_top.sv
